@@ src/mpq_pkg.sv @@
package mpq_pkg;

  // Default number of entries the queue can hold.
  localparam int unsigned CapacityDefault = 16;

  // Fixed field widths of the request and result.
  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 5;

  // Request kinds carried by req_type.
  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } mpq_req_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } mpq_status_e;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic signed [ValueW-1:0] value;
  } mpq_cmd_t;

endpackage

@@ src/min_priority_queue.sv @@
// Bounded min priority queue of signed 32-bit values.
// Input channel (in_valid_i / in_ready_o) carries one request: req_type_i
// selects insert of value_i or removal of the smallest entry.
// Output channel (out_valid_o / out_ready_i) returns one result per request:
// the minimum after the operation (0 when empty), the entry count, an empty
// flag and a status (ok, insert dropped on full, remove on empty).
// Entries live in a row of CAPACITY cells kept sorted ascending; each request
// shifts the row by at most one place, so its result is computed in the cycle
// in which it is accepted and appears in the output register on the next cycle.
// Throughput is one request per cycle while the receiver takes results;
// the single output register sets that figure.
// When the receiver stalls, the result is held and a new request is taken
// only in the cycle in which the held result is taken.
// Reset empties the queue and the output register; no clearing pass is needed.
module min_priority_queue #(
  parameter int unsigned CAPACITY = mpq_pkg::CapacityDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              req_type_i,
  input  logic signed [mpq_pkg::ValueW-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [mpq_pkg::ValueW-1:0] min_value_o,
  output logic        [mpq_pkg::CountW-1:0] entry_count_o,
  output logic                              is_empty_o,
  output logic        [1:0]                 status_o
);
  import mpq_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic                     accept;
  logic                     full, empty;
  mpq_cmd_t                 cmd;
  logic        [CntW-1:0]   count_q, count_d;
  logic signed [ValueW-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]      cell_vld, cell_gt;
  logic signed [ValueW-1:0] head_d;
  mpq_status_e              status_d;

  logic                     out_valid_q;
  logic signed [ValueW-1:0] min_value_q;
  logic [CountW-1:0]        entry_count_q;
  logic                     is_empty_q;
  mpq_status_e              status_q;

  // Accept a request whenever the output register is free or being emptied.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign full  = (count_q == CntW'(CAPACITY));
  assign empty = (count_q == '0);

  // Command broadcast to the row.
  always_comb begin
    cmd.ins   = accept && (req_type_i == REQ_INSERT) && !full;
    cmd.rem   = accept && (req_type_i == REQ_REMOVE) && !empty;
    cmd.value = value_i;
  end

  // Row of sorted cells; each inner cell sees its two neighbors, an end cell one.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     left_gt, left_vld, right_vld;
    logic signed [ValueW-1:0] left_val, right_val;

    if (i == 0) begin : g_first
      assign left_gt  = 1'b0;
      assign left_val = '0;
      assign left_vld = 1'b0;
    end else begin : g_inner_l
      assign left_gt  = cell_gt[i-1];
      assign left_val = cell_val[i-1];
      assign left_vld = cell_vld[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_val = '0;
      assign right_vld = 1'b0;
    end else begin : g_inner_r
      assign right_val = cell_val[i+1];
      assign right_vld = cell_vld[i+1];
    end

    mpq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .left_gt_i   (left_gt),
      .left_val_i  (left_val),
      .left_vld_i  (left_vld),
      .right_val_i (right_val),
      .right_vld_i (right_vld),
      .gt_o        (cell_gt[i]),
      .val_o       (cell_val[i]),
      .vld_o       (cell_vld[i])
    );
  end

  // Entry count and status of the request.
  always_comb begin
    count_d  = count_q;
    status_d = STATUS_OK;
    if (cmd.ins) begin
      count_d = count_q + CntW'(1);
    end else if (cmd.rem) begin
      count_d = count_q - CntW'(1);
    end
    if (accept && (req_type_i == REQ_INSERT) && full) begin
      status_d = STATUS_FULL;
    end else if (accept && (req_type_i == REQ_REMOVE) && empty) begin
      status_d = STATUS_EMPTY;
    end
  end

  // Head of the row after this request, which is the minimum.
  always_comb begin
    if (cmd.rem) begin
      head_d = cell_val[1];
    end else if (cmd.ins && cell_gt[0]) begin
      head_d = value_i;
    end else begin
      head_d = cell_val[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      min_value_q   <= (count_d == '0) ? '0 : head_d;
      entry_count_q <= CountW'(count_d);
      is_empty_q    <= (count_d == '0);
      status_q      <= status_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign min_value_o   = min_value_q;
  assign entry_count_o = entry_count_q;
  assign is_empty_o    = is_empty_q;
  assign status_o      = status_q;

endmodule

@@ src/mpq_cell.sv @@
module mpq_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mpq_pkg::mpq_cmd_t                cmd_i,
  input  logic                             left_gt_i,
  input  logic signed [mpq_pkg::ValueW-1:0] left_val_i,
  input  logic                             left_vld_i,
  input  logic signed [mpq_pkg::ValueW-1:0] right_val_i,
  input  logic                             right_vld_i,
  output logic                             gt_o,
  output logic signed [mpq_pkg::ValueW-1:0] val_o,
  output logic                             vld_o
);
  import mpq_pkg::*;

  logic signed [ValueW-1:0] val_q, val_d;
  logic                     vld_q, vld_d;

  // The new value belongs in front of this cell's entry, or the cell is free.
  assign gt_o = !vld_q || (val_q > cmd_i.value);

  // An insert shifts the tail right from the insertion point; a remove
  // shifts the whole row left by one, dropping the head.
  always_comb begin
    val_d = val_q;
    vld_d = vld_q;
    if (cmd_i.ins) begin
      if (left_gt_i) begin
        val_d = left_val_i;
        vld_d = left_vld_i;
      end else if (gt_o) begin
        val_d = cmd_i.value;
        vld_d = 1'b1;
      end
    end else if (cmd_i.rem) begin
      val_d = right_val_i;
      vld_d = right_vld_i;
    end
  end

  // Entry value needs no reset; the valid bit does.
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign val_o = val_q;
  assign vld_o = vld_q;

endmodule

@@ src/mpq_checker.sv @@
module mpq_checker #(
  parameter int unsigned CAPACITY = mpq_pkg::CapacityDefault
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [mpq_pkg::ValueW-1:0] min_value_o,
  input logic        [mpq_pkg::CountW-1:0] entry_count_o,
  input logic                              is_empty_o,
  input logic        [1:0]                 status_o
);
  import mpq_pkg::*;

  // The empty flag agrees with the reported count.
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (entry_count_o == '0)))
    else $error("empty flag disagrees with entry count");

  // An empty queue reports a minimum of zero.
  a_empty_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_empty_o) |-> (min_value_o == '0))
    else $error("empty queue reports a nonzero minimum");

  // A dropped insert is reported only on a full queue.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == STATUS_FULL)) |-> (entry_count_o == CountW'(CAPACITY)))
    else $error("insert dropped while queue not full");

  // A failed remove is reported only on an empty queue.
  a_rem_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == STATUS_EMPTY)) |-> is_empty_o)
    else $error("remove flagged on a nonempty queue");

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(min_value_o) && $stable(entry_count_o) && $stable(status_o)))
    else $error("stalled result changed");

endmodule

bind min_priority_queue mpq_checker #(.CAPACITY(CAPACITY)) u_mpq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .min_value_o   (min_value_o),
  .entry_count_o (entry_count_o),
  .is_empty_o    (is_empty_o),
  .status_o      (status_o)
);
